@@ hw/rtl/fifoqs_pkg.sv @@
// ----------------------------------------------------------------------------
// fifoqs_pkg
// Shared types and constants for the FIFO queue with membership search.
// ----------------------------------------------------------------------------
package fifoqs_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int OCC_W   = $clog2(DEPTH + 1);
	localparam int WORD_W  = 32;

	typedef enum logic [1:0] {
		CMD_PUT    = 2'd0,
		CMD_GET    = 2'd1,
		CMD_EXISTS = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// Command broadcast along the cell chain
	typedef struct packed {
		logic              shift;   // every cell takes its upper neighbor
		logic              load;    // cell at wr_idx takes data
		logic [IDX_W-1:0]  wr_idx;
		logic [WORD_W-1:0] data;
	} chain_cmd_t;

	// Per-cell control
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

	typedef struct packed {
		logic [OCC_W-1:0]  occupancy;
		logic              is_empty;
		logic [1:0]        status;
		logic              found;
		logic [WORD_W-1:0] data_out;
	} res_t;

endpackage

@@ hw/rtl/fifoqs_cell.sv @@
// ----------------------------------------------------------------------------
// fifoqs_cell
// One storage cell of the queue chain: holds one item, shifts toward the head.
// ----------------------------------------------------------------------------
module fifoqs_cell
	import fifoqs_pkg::*;
(
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [WORD_W-1:0] load_data,
	input  logic [WORD_W-1:0] next_data,
	output logic [WORD_W-1:0] data
);

	logic [WORD_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= load_data;
		end else if (ctrl.shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

@@ hw/rtl/fifoqs_ctrl.sv @@
// ----------------------------------------------------------------------------
// fifoqs_ctrl
// Command sequencer: occupancy, chain control, search scan and result buffer.
// ----------------------------------------------------------------------------
module fifoqs_ctrl
	import fifoqs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [1:0]        s_cmd,
	input  logic [WORD_W-1:0] s_data,
	input  logic [WORD_W-1:0] head_data,
	output chain_cmd_t        chain,
	output logic              m_tvalid,
	input  logic              m_tready,
	output res_t              m_res
);

	state_t             state_q, state_nxt;
	logic [OCC_W-1:0]   count_q, count_nxt;
	logic [IDX_W-1:0]   scan_idx_q, scan_idx_nxt;
	logic               found_q, found_nxt;
	logic [WORD_W-1:0]  key_q, key_nxt;

	logic               out_valid_q;
	res_t               out_q;
	logic               pend_valid_q;
	res_t               pend_q;

	logic               accept;
	logic               push;
	res_t               push_res;
	logic               hit;
	logic               drain;

	assign s_tready = (state_q == ST_IDLE) && !pend_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign drain    = out_valid_q && m_tready;

	// only the first count_q positions of the rotation hold live entries
	assign hit = ({1'b0, scan_idx_q} < count_q) && (head_data == key_q);

	always_comb begin
		state_nxt    = state_q;
		count_nxt    = count_q;
		scan_idx_nxt = scan_idx_q;
		found_nxt    = found_q;
		key_nxt      = key_q;
		push         = 1'b0;
		push_res     = '0;
		chain.shift  = 1'b0;
		chain.load   = 1'b0;
		chain.wr_idx = count_q[IDX_W-1:0];
		chain.data   = s_data;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (s_cmd)
						CMD_PUT: begin
							push = 1'b1;
							if (count_q == OCC_W'(DEPTH)) begin
								push_res.status = STAT_FULL;
							end else begin
								chain.load = 1'b1;
								count_nxt  = count_q + 1'b1;
							end
						end
						CMD_GET: begin
							push = 1'b1;
							if (count_q == '0) begin
								push_res.status   = STAT_EMPTY;
								push_res.data_out = '1;
							end else begin
								chain.shift       = 1'b1;
								push_res.data_out = head_data;
								count_nxt         = count_q - 1'b1;
							end
						end
						CMD_EXISTS: begin
							state_nxt    = ST_SCAN;
							scan_idx_nxt = '0;
							found_nxt    = 1'b0;
							key_nxt      = s_data;
						end
						default: begin
							push = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				// full rotation of the ring restores the original order
				chain.shift  = 1'b1;
				found_nxt    = found_q | hit;
				scan_idx_nxt = scan_idx_q + 1'b1;
				if (scan_idx_q == IDX_W'(DEPTH - 1)) begin
					state_nxt      = ST_IDLE;
					push           = 1'b1;
					push_res.found = found_q | hit;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase

		push_res.occupancy = count_nxt;
		push_res.is_empty  = (count_nxt == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			scan_idx_q <= '0;
			found_q    <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			count_q    <= count_nxt;
			scan_idx_q <= scan_idx_nxt;
			found_q    <= found_nxt;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_nxt;
	end

	// two-entry result buffer; a push never meets a full pending slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (push) begin
				if (!out_valid_q || drain) begin
					out_valid_q <= 1'b1;
				end else begin
					pend_valid_q <= 1'b1;
				end
			end else if (drain) begin
				if (pend_valid_q) begin
					pend_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_valid_q || drain) begin
				out_q <= push_res;
			end else begin
				pend_q <= push_res;
			end
		end else if (drain && pend_valid_q) begin
			out_q <= pend_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_res    = out_q;

endmodule

@@ hw/rtl/fifo_queue_with_search_core.sv @@
// ----------------------------------------------------------------------------
// fifo_queue_with_search_core
// FIFO queue of signed 32-bit items in a chain of cells, with membership search.
// ----------------------------------------------------------------------------
// Put and get: result registered at the accepting edge; one per cycle while s_tready is high.
// Exists query: the cell ring rotates once through all DEPTH cells, comparing at the
// head cell; the result is registered with the last rotation step, then the core returns to idle.
// A two-entry result buffer lets a transaction be taken while one result waits.
// Reset (arst_n low, asynchronous) empties the queue; cell contents are not cleared.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_core
	import fifoqs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // data_in[31:0]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // data_out[31:0], found[32], is_empty[33], occupancy[38:34]
	output logic [1:0]  m_tuser    // status[1:0]
);

	chain_cmd_t        chain;
	res_t              res;
	logic [WORD_W-1:0] cell_data [DEPTH];

	fifoqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_cmd     (s_tuser),
		.s_data    (s_tdata),
		.head_data (cell_data[0]),
		.chain     (chain),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_res     (res)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctrl_t        ctrl;
		logic [WORD_W-1:0] next_data;

		assign ctrl.shift = chain.shift;
		assign ctrl.load  = chain.load && (chain.wr_idx == IDX_W'(i));
		// the last cell closes the ring back to the head
		assign next_data  = cell_data[(i + 1) % DEPTH];

		fifoqs_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.load_data (chain.data),
			.next_data (next_data),
			.data      (cell_data[i])
		);
	end

	assign m_tdata = {1'b0, res.occupancy, res.is_empty, res.found, res.data_out};
	assign m_tuser = res.status;

endmodule
